### rtl/dcl_pkg.sv
// dcl_pkg: shared types, constants and arithmetic step functions for the
// degenerate conic to lines pipeline. No dependencies.
package dcl_pkg;

   localparam int FRAC_W      = 16;
   localparam int DIV_STEPS   = 31;
   localparam int ROOT_STEPS  = 32;
   localparam int LINE_W      = 49;

   typedef logic signed [31:0] word_type;
   typedef logic signed [63:0] wide_type;
   typedef logic signed [LINE_W-1:0] line_type;

   localparam word_type ONE_Q = 32'sd65536;
   localparam logic [30:0] MAG_MAX = '1;

   typedef enum logic [2:0] {
      CASE_HV     = 3'd0,
      CASE_PAR    = 3'd1,
      CASE_INT    = 3'd2,
      CASE_PAR_NR = 3'd3,
      CASE_INT_NR = 3'd4
   } case_type;

   // data carried alongside for the horizontal/vertical case and swap back
   typedef struct {
      logic     hv;
      logic     swap;
      word_type g1;
      word_type g2;
      word_type g5;
   } side_type;

   // restoring division state, 32 bit divisor
   typedef struct {
      logic [31:0] rem;
      logic [30:0] nb;
      logic [30:0] quot;
   } div32_type;

   // restoring division state, 64 bit divisor
   typedef struct {
      logic [63:0] rem;
      logic [30:0] nb;
      logic [30:0] quot;
   } div64_type;

   // digit recurrence square root state
   typedef struct {
      logic [63:0] x;
      logic [34:0] rem;
      logic [31:0] root;
   } sqrt_type;

   // scaling divider stage contents
   typedef struct {
      side_type    side;
      logic [31:0] d;
      logic        neg [9];
      logic        ovf [9];
      div32_type   dv [9];
   } prep_type;

   // scaled matrix
   typedef struct {
      side_type side;
      logic     f;
      word_type s [9];
   } scaled_type;

   // root and ratio stage contents
   typedef struct {
      side_type    side;
      logic        f;
      case_type    code;
      word_type    s1;
      word_type    s5;
      logic [63:0] d;
      logic        neg12;
      logic        neg02;
      logic        ovf12;
      logic        ovf02;
      div64_type   dv12;
      div64_type   dv02;
      sqrt_type    sq;
   } cof_type;

   // one result item
   typedef struct {
      word_type ln [6];
      case_type code;
      logic     sat;
   } res_type;

   function automatic logic [31:0] abs32(word_type v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic [63:0] abs64(wide_type v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic div32_type div32_step(div32_type cur, logic [31:0] d);
      div32_type   nxt;
      logic [32:0] r2;
      r2 = {cur.rem, cur.nb[30]};
      nxt.nb = {cur.nb[29:0], 1'b0};
      if (r2 >= {1'b0, d}) begin
         nxt.rem  = 32'(r2 - {1'b0, d});
         nxt.quot = {cur.quot[29:0], 1'b1};
      end else begin
         nxt.rem  = r2[31:0];
         nxt.quot = {cur.quot[29:0], 1'b0};
      end
      return nxt;
   endfunction

   function automatic div64_type div64_step(div64_type cur, logic [63:0] d);
      div64_type   nxt;
      logic [64:0] r2;
      r2 = {cur.rem, cur.nb[30]};
      nxt.nb = {cur.nb[29:0], 1'b0};
      if (r2 >= {1'b0, d}) begin
         nxt.rem  = 64'(r2 - {1'b0, d});
         nxt.quot = {cur.quot[29:0], 1'b1};
      end else begin
         nxt.rem  = r2[63:0];
         nxt.quot = {cur.quot[29:0], 1'b0};
      end
      return nxt;
   endfunction

   function automatic sqrt_type sqrt_step(sqrt_type cur);
      sqrt_type    nxt;
      logic [34:0] r2;
      logic [34:0] trial;
      r2    = {cur.rem[32:0], cur.x[63:62]};
      trial = {1'b0, cur.root, 2'b01};
      nxt.x = {cur.x[61:0], 2'b00};
      if (r2 >= trial) begin
         nxt.rem  = r2 - trial;
         nxt.root = {cur.root[30:0], 1'b1};
      end else begin
         nxt.rem  = r2;
         nxt.root = {cur.root[30:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

### rtl/dcl_prep.sv
// dcl_prep: entry stage, axis swap and divider operand setup.
// Depends on dcl_pkg.
module dcl_prep import dcl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_valid,
   input  word_type a [9],
   output logic     out_valid,
   output prep_type out_data
);

   prep_type    st_ff, st_in;
   logic        vld_ff;
   word_type    q [9];
   logic [31:0] mag [9];

   // swap axes when |a00| > |a11|, set up scaling by q11
   always_comb begin
      st_in.side.hv   = (a[0] == '0) && (a[4] == '0);
      st_in.side.swap = abs32(a[0]) > abs32(a[4]);
      st_in.side.g1   = a[1];
      st_in.side.g2   = a[2];
      st_in.side.g5   = a[5];
      if (st_in.side.swap) begin
         q[0] = a[4]; q[1] = a[3]; q[2] = a[5];
         q[3] = a[1]; q[4] = a[0]; q[5] = a[2];
         q[6] = a[7]; q[7] = a[6]; q[8] = a[8];
      end else begin
         for (int k = 0; k < 9; k++) q[k] = a[k];
      end
      st_in.d = abs32(q[4]);
      for (int k = 0; k < 9; k++) begin
         mag[k]           = abs32(q[k]);
         st_in.neg[k]     = q[k][31] ^ q[4][31];
         st_in.dv[k].rem  = {15'b0, mag[k][31:15]};
         st_in.dv[k].nb   = {mag[k][14:0], 16'b0};
         st_in.dv[k].quot = '0;
         st_in.ovf[k]     = {15'b0, mag[k][31:15]} >= st_in.d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = st_ff;

endmodule

### rtl/dcl_scale.sv
// dcl_scale: nine parallel restoring dividers, one quotient bit per stage,
// then sign and clip. Depends on dcl_pkg.
module dcl_scale import dcl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  logic       in_valid,
   input  prep_type   in_data,
   output logic       out_valid,
   output scaled_type out_data
);

   prep_type               st_ff [DIV_STEPS];
   prep_type               st_in [DIV_STEPS];
   logic [DIV_STEPS-1:0]   vld_ff;
   scaled_type             out_ff, out_in;
   logic                   out_vld_ff;
   logic [30:0]            mag [9];

   function automatic prep_type step_all(prep_type cur);
      prep_type nxt;
      nxt = cur;
      for (int k = 0; k < 9; k++) nxt.dv[k] = div32_step(cur.dv[k], cur.d);
      return nxt;
   endfunction

   // divider stages
   always_comb begin
      st_in[0] = step_all(in_data);
      for (int i = 1; i < DIV_STEPS; i++) st_in[i] = step_all(st_ff[i-1]);
   end

   // sign, clip and clip flag
   always_comb begin
      out_in.side = st_ff[DIV_STEPS-1].side;
      out_in.f    = 1'b0;
      for (int k = 0; k < 9; k++) begin
         mag[k] = st_ff[DIV_STEPS-1].ovf[k] ? MAG_MAX : st_ff[DIV_STEPS-1].dv[k].quot;
         out_in.s[k] = st_ff[DIV_STEPS-1].neg[k] ? -$signed({1'b0, mag[k]})
                                                 : $signed({1'b0, mag[k]});
         if (st_ff[DIV_STEPS-1].ovf[k] && !st_ff[DIV_STEPS-1].side.hv) begin
            out_in.f = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[DIV_STEPS-2:0], in_valid};
         out_vld_ff <= vld_ff[DIV_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < DIV_STEPS; i++) st_ff[i] <= st_in[i];
         out_ff <= out_in;
      end
   end

   assign out_valid = out_vld_ff;
   assign out_data  = out_ff;

endmodule

### rtl/dcl_cofactor.sv
// dcl_cofactor: cofactor products, differences, case decision and setup of
// the root and ratio operands. Depends on dcl_pkg.
module dcl_cofactor import dcl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  word_type   zero_threshold,
   input  logic       in_valid,
   input  scaled_type in_data,
   output logic       out_valid,
   output cof_type    out_data
);

   typedef struct {
      side_type side;
      logic     f;
      word_type s1;
      word_type s5;
      wide_type p [8];
   } prod_type;

   typedef struct {
      side_type side;
      logic     f;
      word_type s1;
      word_type s5;
      case_type code;
      wide_type c00;
      wide_type c22;
      wide_type c02;
      wide_type c12;
   } diff_type;

   prod_type    p_ff, p_in;
   diff_type    d_ff, d_in;
   cof_type     c_ff, c_in;
   logic [2:0]  vld_ff;
   wide_type    thr;
   logic [63:0] n12, n02;

   // eight products of the scaled entries
   always_comb begin
      p_in.side = in_data.side;
      p_in.f    = in_data.f;
      p_in.s1   = in_data.s[1];
      p_in.s5   = in_data.s[5];
      p_in.p[0] = in_data.s[0] * in_data.s[4];
      p_in.p[1] = in_data.s[1] * in_data.s[3];
      p_in.p[2] = in_data.s[4] * in_data.s[8];
      p_in.p[3] = in_data.s[5] * in_data.s[7];
      p_in.p[4] = in_data.s[3] * in_data.s[7];
      p_in.p[5] = in_data.s[4] * in_data.s[6];
      p_in.p[6] = in_data.s[1] * in_data.s[6];
      p_in.p[7] = in_data.s[0] * in_data.s[7];
   end

   // cofactors and case decision
   always_comb begin
      thr       = {{16{zero_threshold[31]}}, zero_threshold, 16'b0};
      d_in.side = p_ff.side;
      d_in.f    = p_ff.f;
      d_in.s1   = p_ff.s1;
      d_in.s5   = p_ff.s5;
      d_in.c22  = p_ff.p[0] - p_ff.p[1];
      d_in.c00  = p_ff.p[2] - p_ff.p[3];
      d_in.c02  = p_ff.p[4] - p_ff.p[5];
      d_in.c12  = p_ff.p[6] - p_ff.p[7];
      if (p_ff.side.hv) begin
         d_in.code = CASE_HV;
      end else if (d_in.c22 >= thr) begin
         d_in.code = (d_in.c00 > 0) ? CASE_PAR_NR : CASE_PAR;
      end else if (d_in.c22 >= 0) begin
         d_in.code = CASE_INT_NR;
      end else begin
         d_in.code = CASE_INT;
      end
   end

   // radicand and ratio divider setup
   always_comb begin
      c_in.side      = d_ff.side;
      c_in.f         = d_ff.f;
      c_in.code      = d_ff.code;
      c_in.s1        = d_ff.s1;
      c_in.s5        = d_ff.s5;
      c_in.sq.x      = (d_ff.code == CASE_PAR) ? 64'(-d_ff.c00) : 64'(-d_ff.c22);
      c_in.sq.rem    = '0;
      c_in.sq.root   = '0;
      c_in.d         = abs64(d_ff.c22);
      n12            = abs64(d_ff.c12);
      n02            = abs64(d_ff.c02);
      c_in.neg12     = d_ff.c12[63] ^ d_ff.c22[63];
      c_in.neg02     = d_ff.c02[63] ^ d_ff.c22[63];
      c_in.ovf12     = {15'b0, n12[63:15]} >= c_in.d;
      c_in.ovf02     = {15'b0, n02[63:15]} >= c_in.d;
      c_in.dv12.rem  = {15'b0, n12[63:15]};
      c_in.dv12.nb   = {n12[14:0], 16'b0};
      c_in.dv12.quot = '0;
      c_in.dv02.rem  = {15'b0, n02[63:15]};
      c_in.dv02.nb   = {n02[14:0], 16'b0};
      c_in.dv02.quot = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff <= p_in;
         d_ff <= d_in;
         c_ff <= c_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_data  = c_ff;

endmodule

### rtl/dcl_rootdiv.sv
// dcl_rootdiv: square root, one root bit per stage, alongside the two
// ratio dividers, one quotient bit per stage. Depends on dcl_pkg.
module dcl_rootdiv import dcl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  logic    in_valid,
   input  cof_type in_data,
   output logic    out_valid,
   output cof_type out_data
);

   cof_type               st_ff [ROOT_STEPS];
   cof_type               st_in [ROOT_STEPS];
   logic [ROOT_STEPS-1:0] vld_ff;

   function automatic cof_type step_all(cof_type cur, logic do_div);
      cof_type nxt;
      nxt    = cur;
      nxt.sq = sqrt_step(cur.sq);
      if (do_div) begin
         nxt.dv12 = div64_step(cur.dv12, cur.d);
         nxt.dv02 = div64_step(cur.dv02, cur.d);
      end
      return nxt;
   endfunction

   // root and ratio stages; the ratios need one step less than the root
   always_comb begin
      st_in[0] = step_all(in_data, 1'b1);
      for (int i = 1; i < ROOT_STEPS; i++) begin
         st_in[i] = step_all(st_ff[i-1], i < DIV_STEPS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[ROOT_STEPS-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < ROOT_STEPS; i++) st_ff[i] <= st_in[i];
      end
   end

   assign out_valid = vld_ff[ROOT_STEPS-1];
   assign out_data  = st_ff[ROOT_STEPS-1];

endmodule

### rtl/dcl_lines.sv
// dcl_lines: line assembly, products with the ratio, output clip, axis swap
// back and the output register. Depends on dcl_pkg.
module dcl_lines import dcl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  logic    in_valid,
   input  cof_type in_data,
   output logic    out_valid,
   output res_type out_data
);

   typedef struct {
      side_type            side;
      logic                f;
      case_type            code;
      word_type            s1;
      word_type            t12;
      word_type            t02;
      word_type            mm;
      word_type            mp;
      logic signed [33:0]  wm;
      logic signed [33:0]  wp;
   } l1_type;

   typedef struct {
      side_type            side;
      logic                f;
      case_type            code;
      word_type            s1;
      word_type            t12;
      word_type            mm;
      word_type            mp;
      logic signed [33:0]  wm;
      logic signed [33:0]  wp;
      wide_type            pm;
      wide_type            pp;
   } l2_type;

   typedef struct {
      logic     swap;
      logic     f;
      case_type code;
      line_type ln [6];
   } l3_type;

   l1_type             l1_ff, l1_in;
   l2_type             l2_ff, l2_in;
   l3_type             l3_ff, l3_in;
   res_type            out_ff, out_in;
   logic [3:0]         vld_ff;
   logic [30:0]        mag12, mag02;
   logic signed [33:0] dm, dp;
   logic [32:0]        cm, cp;
   logic [32:0]        co [6];
   word_type           lc [6];
   logic               any_clip;

   // symmetric clip to +-(2^31-1), flag in the top bit
   function automatic logic [32:0] clip_sym(logic signed [33:0] v);
      if (v > 34'sd2147483647) begin
         return {1'b1, 32'sd2147483647};
      end else if (v < -34'sd2147483647) begin
         return {1'b1, -32'sd2147483647};
      end
      return {1'b0, v[31:0]};
   endfunction

   // output clip to the 32 bit range, flag in the top bit
   function automatic logic [32:0] clip_out(line_type v);
      if (v > LINE_W'(32'sh7fffffff)) begin
         return {1'b1, 32'h7fffffff};
      end else if (v < LINE_W'(-33'sh80000000)) begin
         return {1'b1, 32'h80000000};
      end
      return {1'b0, v[31:0]};
   endfunction

   // signed ratios and the two slopes
   always_comb begin
      mag12      = in_data.ovf12 ? MAG_MAX : in_data.dv12.quot;
      mag02      = in_data.ovf02 ? MAG_MAX : in_data.dv02.quot;
      l1_in.side = in_data.side;
      l1_in.code = in_data.code;
      l1_in.s1   = in_data.s1;
      l1_in.t12  = in_data.neg12 ? -$signed({1'b0, mag12}) : $signed({1'b0, mag12});
      l1_in.t02  = in_data.neg02 ? -$signed({1'b0, mag02}) : $signed({1'b0, mag02});
      dm         = 34'(in_data.s1) - $signed({2'b00, in_data.sq.root});
      dp         = 34'(in_data.s1) + $signed({2'b00, in_data.sq.root});
      cm         = clip_sym(dm);
      cp         = clip_sym(dp);
      l1_in.mm   = cm[31:0];
      l1_in.mp   = cp[31:0];
      l1_in.wm   = 34'(in_data.s5) - $signed({2'b00, in_data.sq.root});
      l1_in.wp   = 34'(in_data.s5) + $signed({2'b00, in_data.sq.root});
      l1_in.f    = in_data.f || ((in_data.code == CASE_INT) &&
                   (in_data.ovf12 || in_data.ovf02 || cm[32] || cp[32]));
   end

   // slope times ratio
   always_comb begin
      l2_in.side = l1_ff.side;
      l2_in.f    = l1_ff.f;
      l2_in.code = l1_ff.code;
      l2_in.s1   = l1_ff.s1;
      l2_in.t12  = l1_ff.t12;
      l2_in.mm   = l1_ff.mm;
      l2_in.mp   = l1_ff.mp;
      l2_in.wm   = l1_ff.wm;
      l2_in.wp   = l1_ff.wp;
      l2_in.pm   = l1_ff.mm * l1_ff.t02;
      l2_in.pp   = l1_ff.mp * l1_ff.t02;
   end

   // line coefficients per case
   always_comb begin
      l3_in.swap = l2_ff.side.swap;
      l3_in.f    = l2_ff.f;
      l3_in.code = l2_ff.code;
      for (int k = 0; k < 6; k++) l3_in.ln[k] = '0;
      case (l2_ff.code)
         CASE_HV: begin
            l3_in.ln[0] = LINE_W'(l2_ff.side.g1);
            l3_in.ln[2] = LINE_W'(l2_ff.side.g5);
            l3_in.ln[4] = LINE_W'(l2_ff.side.g1);
            l3_in.ln[5] = LINE_W'(l2_ff.side.g2) - LINE_W'(l2_ff.side.g5);
         end
         CASE_PAR: begin
            l3_in.ln[0] = LINE_W'(l2_ff.s1);
            l3_in.ln[1] = LINE_W'(ONE_Q);
            l3_in.ln[2] = LINE_W'(l2_ff.wm);
            l3_in.ln[3] = LINE_W'(l2_ff.s1);
            l3_in.ln[4] = LINE_W'(ONE_Q);
            l3_in.ln[5] = LINE_W'(l2_ff.wp);
         end
         CASE_INT: begin
            l3_in.ln[0] = LINE_W'(l2_ff.mm);
            l3_in.ln[1] = LINE_W'(ONE_Q);
            l3_in.ln[2] = -LINE_W'(l2_ff.t12) - LINE_W'(l2_ff.pm >>> FRAC_W);
            l3_in.ln[3] = LINE_W'(l2_ff.mp);
            l3_in.ln[4] = LINE_W'(ONE_Q);
            l3_in.ln[5] = -LINE_W'(l2_ff.t12) - LINE_W'(l2_ff.pp >>> FRAC_W);
         end
         default: begin
            for (int k = 0; k < 6; k++) l3_in.ln[k] = '0;
         end
      endcase
   end

   // output clip and swap back
   always_comb begin
      any_clip = 1'b0;
      for (int k = 0; k < 6; k++) begin
         co[k] = clip_out(l3_ff.ln[k]);
         lc[k] = co[k][31:0];
         any_clip = any_clip | co[k][32];
      end
      out_in.code = l3_ff.code;
      out_in.sat  = l3_ff.f | any_clip;
      for (int k = 0; k < 6; k++) out_in.ln[k] = lc[k];
      if (l3_ff.swap && ((l3_ff.code == CASE_PAR) || (l3_ff.code == CASE_INT))) begin
         out_in.ln[0] = lc[1];
         out_in.ln[1] = lc[0];
         out_in.ln[3] = lc[4];
         out_in.ln[4] = lc[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         l1_ff  <= l1_in;
         l2_ff  <= l2_in;
         l3_ff  <= l3_in;
         out_ff <= out_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_data  = out_ff;

endmodule

### rtl/degenerate_conic_to_lines_top.sv
// degenerate_conic_to_lines_top: splits a degenerate conic into two lines.
// Depends on dcl_pkg, dcl_prep, dcl_scale, dcl_cofactor, dcl_rootdiv, dcl_lines.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_a00 .. req_a22
//   rsp      out        rsp_valid/rsp_stall  rsp_plus_*, rsp_minus_*, code, flag
//   csr      in         csr_wr_en            csr_wr_data (zero threshold)
//
// one matrix per cycle while rsp_stall does not hold the pipeline: the 31
// bit scaling dividers and the 32 stage square root set the depth
// the whole pipeline holds while a result waits under rsp_stall
// synchronous reset clears the valid bits and sets the threshold to zero
module degenerate_conic_to_lines_top import dcl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_a00,
   input  logic [31:0] req_a01,
   input  logic [31:0] req_a02,
   input  logic [31:0] req_a10,
   input  logic [31:0] req_a11,
   input  logic [31:0] req_a12,
   input  logic [31:0] req_a20,
   input  logic [31:0] req_a21,
   input  logic [31:0] req_a22,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_plus_x,
   output logic [31:0] rsp_plus_y,
   output logic [31:0] rsp_plus_w,
   output logic [31:0] rsp_minus_x,
   output logic [31:0] rsp_minus_y,
   output logic [31:0] rsp_minus_w,
   output logic [2:0]  rsp_case_code,
   output logic        rsp_saturated,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   word_type   zt_ff, zt_in;
   logic       adv;
   word_type   a [9];
   logic       prep_v, scale_v, cof_v, rd_v;
   prep_type   prep_d;
   scaled_type scale_d;
   cof_type    cof_d, rd_d;
   res_type    res;

   // threshold register
   assign zt_in = csr_wr_en ? word_type'(csr_wr_data) : zt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zt_ff <= '0;
      end else begin
         zt_ff <= zt_in;
      end
   end

   // pipeline moves unless the output holds a stalled result
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   assign a[0] = req_a00;
   assign a[1] = req_a01;
   assign a[2] = req_a02;
   assign a[3] = req_a10;
   assign a[4] = req_a11;
   assign a[5] = req_a12;
   assign a[6] = req_a20;
   assign a[7] = req_a21;
   assign a[8] = req_a22;

   dcl_prep u_prep (
      .clock, .reset, .adv,
      .in_valid(req_valid), .a,
      .out_valid(prep_v), .out_data(prep_d)
   );

   dcl_scale u_scale (
      .clock, .reset, .adv,
      .in_valid(prep_v), .in_data(prep_d),
      .out_valid(scale_v), .out_data(scale_d)
   );

   dcl_cofactor u_cofactor (
      .clock, .reset, .adv,
      .zero_threshold(zt_ff),
      .in_valid(scale_v), .in_data(scale_d),
      .out_valid(cof_v), .out_data(cof_d)
   );

   dcl_rootdiv u_rootdiv (
      .clock, .reset, .adv,
      .in_valid(cof_v), .in_data(cof_d),
      .out_valid(rd_v), .out_data(rd_d)
   );

   dcl_lines u_lines (
      .clock, .reset, .adv,
      .in_valid(rd_v), .in_data(rd_d),
      .out_valid(rsp_valid), .out_data(res)
   );

   assign rsp_plus_x    = res.ln[0];
   assign rsp_plus_y    = res.ln[1];
   assign rsp_plus_w    = res.ln[2];
   assign rsp_minus_x   = res.ln[3];
   assign rsp_minus_y   = res.ln[4];
   assign rsp_minus_w   = res.ln[5];
   assign rsp_case_code = res.code;
   assign rsp_saturated = res.sat;

   // no real solution gives all zero lines
   a_no_real_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_case_code == CASE_PAR_NR || rsp_case_code == CASE_INT_NR)
      |-> (rsp_plus_x == '0) && (rsp_plus_y == '0) && (rsp_plus_w == '0) &&
          (rsp_minus_x == '0) && (rsp_minus_y == '0) && (rsp_minus_w == '0))
      else $error("nonzero line in a no real solution result");

   // horizontal/vertical pair has its zero components in place
   a_hv_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_case_code == CASE_HV)
      |-> (rsp_plus_y == '0) && (rsp_minus_x == '0) && (rsp_plus_x == rsp_minus_y))
      else $error("horizontal/vertical result malformed");

   // parallel lines share their direction
   a_par_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_case_code == CASE_PAR)
      |-> (rsp_plus_x == rsp_minus_x) && (rsp_plus_y == rsp_minus_y))
      else $error("parallel lines differ in direction");

endmodule
